### design/tun_pkg.sv
`default_nettype none
package tun_pkg;
  localparam int COORD_W = 16;
  localparam int EDGE_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * EDGE_W;
  localparam int MAG_W   = PROD_W;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int LEN_W   = SQ_W + 2;
  localparam int FRAC_W  = 14;
  localparam int Q_W     = FRAC_W + 1;
  localparam int R_W     = SQ_W + 2 * FRAC_W;
  localparam int P_W     = LEN_W + Q_W;
  localparam int D_W     = P_W + Q_W + 1;
  localparam int OUT_W   = 16;
  localparam int LANES   = 3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [EDGE_W-1:0]  edge_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic [MAG_W-1:0]          mag_t;
  typedef logic [SQ_W-1:0]           sq_t;
  typedef logic [LEN_W-1:0]          len_t;
  typedef logic [Q_W-1:0]            quot_t;

  // control that travels with each item
  typedef struct packed {
    logic valid;
    logic neg;
    logic degen;
  } tun_side_t;
endpackage
`default_nettype wire

### design/tun_cross.sv
`default_nettype none
module tun_cross (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  input  wire tun_pkg::coord_t                        v0_x,
  input  wire tun_pkg::coord_t                        v0_y,
  input  wire tun_pkg::coord_t                        v0_z,
  input  wire tun_pkg::coord_t                        v1_x,
  input  wire tun_pkg::coord_t                        v1_y,
  input  wire tun_pkg::coord_t                        v1_z,
  input  wire tun_pkg::coord_t                        v2_x,
  input  wire tun_pkg::coord_t                        v2_y,
  input  wire tun_pkg::coord_t                        v2_z,
  output logic                                        out_valid,
  output tun_pkg::mag_t                               mag [tun_pkg::LANES],
  output logic [tun_pkg::LANES-1:0]                   neg
);
  import tun_pkg::*;

  logic  valid1, valid2;
  edge_t e1 [LANES];
  edge_t e2 [LANES];
  prod_t prod [2*LANES];
  logic signed [PROD_W:0] n_comb [LANES];

  // edge vectors
  always_ff @(posedge clk) begin
    e1[0] <= EDGE_W'(v1_x) - EDGE_W'(v0_x);
    e1[1] <= EDGE_W'(v1_y) - EDGE_W'(v0_y);
    e1[2] <= EDGE_W'(v1_z) - EDGE_W'(v0_z);
    e2[0] <= EDGE_W'(v2_x) - EDGE_W'(v0_x);
    e2[1] <= EDGE_W'(v2_y) - EDGE_W'(v0_y);
    e2[2] <= EDGE_W'(v2_z) - EDGE_W'(v0_z);
  end

  // six partial products of e2 x e1
  always_ff @(posedge clk) begin
    prod[0] <= e2[1] * e1[2];
    prod[1] <= e2[2] * e1[1];
    prod[2] <= e2[2] * e1[0];
    prod[3] <= e2[0] * e1[2];
    prod[4] <= e2[0] * e1[1];
    prod[5] <= e2[1] * e1[0];
  end

  // cross components, split into sign and magnitude
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      n_comb[k] = (PROD_W+1)'(prod[2*k]) - (PROD_W+1)'(prod[2*k+1]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < LANES; k++) begin
      neg[k] <= n_comb[k][PROD_W];
      mag[k] <= n_comb[k][PROD_W] ? MAG_W'(-n_comb[k]) : MAG_W'(n_comb[k]);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1    <= 1'b0;
      valid2    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      valid1    <= in_valid;
      valid2    <= valid1;
      out_valid <= valid2;
    end
  end
endmodule
`default_nettype wire

### design/tun_len.sv
`default_nettype none
module tun_len (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  input  wire tun_pkg::mag_t           mag [tun_pkg::LANES],
  output logic                         out_valid,
  output logic                         degen,
  output tun_pkg::sq_t                 sq [tun_pkg::LANES],
  output tun_pkg::len_t                len
);
  import tun_pkg::*;

  logic valid1;
  sq_t  sq1 [LANES];
  len_t len_comb;

  // component squares
  always_ff @(posedge clk) begin
    for (int k = 0; k < LANES; k++) begin
      sq1[k] <= SQ_W'(mag[k]) * SQ_W'(mag[k]);
    end
  end

  // squared length
  assign len_comb = LEN_W'(sq1[0]) + LEN_W'(sq1[1]) + LEN_W'(sq1[2]);

  always_ff @(posedge clk) begin
    len   <= len_comb;
    degen <= (len_comb == '0);
    for (int k = 0; k < LANES; k++) begin
      sq[k] <= sq1[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      valid1    <= in_valid;
      out_valid <= valid1;
    end
  end
endmodule
`default_nettype wire

### design/tun_quot.sv
`default_nettype none
module tun_quot (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire tun_pkg::tun_side_t   in_side,
  input  wire tun_pkg::sq_t         sq,
  input  wire tun_pkg::len_t        len,
  output tun_pkg::tun_side_t        out_side,
  output tun_pkg::quot_t            quot
);
  import tun_pkg::*;

  // one stage per quotient bit: largest q with q*q*len <= sq << 2*FRAC_W
  // r holds the remaining target, p holds len*q
  logic [R_W-1:0] r  [Q_W+1];
  logic [P_W-1:0] p  [Q_W+1];
  quot_t          q  [Q_W+1];
  len_t           ln [Q_W+1];
  tun_side_t      sd [Q_W+1];

  assign r[0]  = R_W'(sq) << (2 * FRAC_W);
  assign p[0]  = '0;
  assign q[0]  = '0;
  assign ln[0] = len;
  assign sd[0] = in_side;

  for (genvar i = 0; i < Q_W; i++) begin : g_bit
    localparam int B = FRAC_W - i;
    logic [D_W-1:0] delta;
    logic           take;

    // growth of q*q*len when bit B is set
    assign delta = (D_W'(p[i]) << (B + 1)) + (D_W'(ln[i]) << (2 * B));
    assign take  = D_W'(r[i]) >= delta;

    always_ff @(posedge clk) begin
      ln[i+1] <= ln[i];
      if (take) begin
        r[i+1] <= R_W'(D_W'(r[i]) - delta);
        p[i+1] <= p[i] + (P_W'(ln[i]) << B);
        q[i+1] <= q[i] | (Q_W'(1) << B);
      end else begin
        r[i+1] <= r[i];
        p[i+1] <= p[i];
        q[i+1] <= q[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sd[i+1].valid <= 1'b0;
      end else begin
        sd[i+1].valid <= sd[i].valid;
      end
      sd[i+1].neg   <= sd[i].neg;
      sd[i+1].degen <= sd[i].degen;
    end
  end

  assign out_side = sd[Q_W];
  assign quot     = q[Q_W];
endmodule
`default_nettype wire

### design/triangle_unit_normal.sv
`default_nettype none
// triangle_unit_normal: unit face normal of a triangle in fixed point.
// Input: raise start with the nine vertex coordinates (signed Q8.8);
// the triangle is taken on a clock edge where start is high and busy is
// low. busy is low whenever rst is low, so one triangle can be taken
// every cycle.
// Output: done is high for exactly one cycle with normal_x/y/z (signed
// Q1.14, truncated toward zero) and degenerate. A degenerate triangle
// (zero cross product) gives a zero normal with degenerate set.
// Throughput one triangle per cycle. The pipeline holds five
// arithmetic stages (edges, products, cross, squares, length sum),
// a 15-stage restoring square-root-ratio pipeline, one bit per stage,
// and the output register.
// Reset: rst clears all valid bits; items in flight are dropped.
// The receiver cannot stall; results are shown once and never held.
module triangle_unit_normal (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire tun_pkg::coord_t v0_x,
  input  wire tun_pkg::coord_t v0_y,
  input  wire tun_pkg::coord_t v0_z,
  input  wire tun_pkg::coord_t v1_x,
  input  wire tun_pkg::coord_t v1_y,
  input  wire tun_pkg::coord_t v1_z,
  input  wire tun_pkg::coord_t v2_x,
  input  wire tun_pkg::coord_t v2_y,
  input  wire tun_pkg::coord_t v2_z,
  output logic                 done,
  output logic signed [15:0]   normal_x,
  output logic signed [15:0]   normal_y,
  output logic signed [15:0]   normal_z,
  output logic                 degenerate
);
  import tun_pkg::*;

  logic            cross_valid;
  mag_t            mag [LANES];
  logic [LANES-1:0] neg;
  logic            len_valid;
  logic            len_degen;
  sq_t             sq [LANES];
  len_t            len;
  tun_side_t       lane_in  [LANES];
  tun_side_t       lane_out [LANES];
  quot_t           quot     [LANES];
  logic [OUT_W-1:0] comp    [LANES];

  assign busy = rst;

  tun_cross u_cross (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .v0_x      (v0_x),
    .v0_y      (v0_y),
    .v0_z      (v0_z),
    .v1_x      (v1_x),
    .v1_y      (v1_y),
    .v1_z      (v1_z),
    .v2_x      (v2_x),
    .v2_y      (v2_y),
    .v2_z      (v2_z),
    .out_valid (cross_valid),
    .mag       (mag),
    .neg       (neg)
  );

  // sign bits wait out the two length stages
  logic [LANES-1:0] neg_d1, neg_d2;
  always_ff @(posedge clk) begin
    neg_d1 <= neg;
    neg_d2 <= neg_d1;
  end

  tun_len u_len (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cross_valid),
    .mag       (mag),
    .out_valid (len_valid),
    .degen     (len_degen),
    .sq        (sq),
    .len       (len)
  );

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    assign lane_in[k] = '{valid: len_valid, neg: neg_d2[k], degen: len_degen};

    tun_quot u_quot (
      .clk      (clk),
      .rst      (rst),
      .in_side  (lane_in[k]),
      .sq       (sq[k]),
      .len      (len),
      .out_side (lane_out[k]),
      .quot     (quot[k])
    );

    // apply sign, zero out degenerate results
    always_comb begin
      if (lane_out[k].degen) begin
        comp[k] = '0;
      end else if (lane_out[k].neg) begin
        comp[k] = OUT_W'(-OUT_W'(quot[k]));
      end else begin
        comp[k] = OUT_W'(quot[k]);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    normal_x   <= comp[0];
    normal_y   <= comp[1];
    normal_z   <= comp[2];
    degenerate <= lane_out[0].degen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= lane_out[0].valid;
    end
  end

  // a degenerate result carries a zero normal
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    done && degenerate |-> normal_x == 16'sd0 && normal_y == 16'sd0 && normal_z == 16'sd0)
    else $error("degenerate result with nonzero normal");

  // normal_x and normal_z stay inside the unit range
  a_x_range: assert property (@(posedge clk) disable iff (rst)
    done |-> normal_x >= -16'sd16384 && normal_x <= 16'sd16384)
    else $error("normal_x out of unit range");

  a_z_range: assert property (@(posedge clk) disable iff (rst)
    done |-> normal_z >= -16'sd16384 && normal_z <= 16'sd16384)
    else $error("normal_z out of unit range");
endmodule
`default_nettype wire
